FILE: rtl/cbrm_pkg.sv
// Shared types and codes for the contiguous block ring manager.
// No dependencies; every other file imports this package.
package cbrm_pkg;

    // Default pointer width
    localparam int POS_BITS_DEFAULT = 16;

    // Field widths
    localparam int LEN_W    = 16;
    localparam int OFS_W    = 17;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths (data padded to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVE_SIZE   = 1'd1;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] WCAP_RESET = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] RSV_RESET  = 16'd512;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_W_RESERVE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_W_COMMIT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_W_CLOSE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_R_OPEN    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_R_CLOSE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK              = 4'd0,
        ST_ERROR           = 4'd1,
        ST_WRITE_BUSY      = 4'd2,
        ST_NO_SPACE        = 4'd3,
        ST_WRITE_NOTHING   = 4'd4,
        ST_WRITE_NOT_START = 4'd5,
        ST_OUT_OF_BOUNDS   = 4'd6,
        ST_READ_BUSY       = 4'd7,
        ST_READ_NOTHING    = 4'd8,
        ST_EMPTY           = 4'd9,
        ST_INCOMPLETE      = 4'd10,
        ST_READ_NOT_START  = 4'd11
    } t_status;

    // Where the open write block was placed
    typedef enum logic [1:0] {
        PLACE_NONE      = 2'd0,
        PLACE_TAIL_END  = 2'd1,
        PLACE_TAIL_HEAD = 2'd2,
        PLACE_ZERO      = 2'd3
    } t_place;

    // One registered request
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] chunk_offset;
        logic             need_complete;
    } t_req;

    // One result
    typedef struct packed {
        t_status                 status;
        logic signed [OFS_W-1:0] block_offset;
        logic [LEN_W-1:0]        block_size;
        logic                    move_valid;
        logic [LEN_W-1:0]        move_source;
        logic signed [OFS_W-1:0] move_dest;
        logic [LEN_W-1:0]        move_length;
    } t_result;

endpackage

FILE: rtl/cbrm_engine.sv
// Pointer state, configuration registers and per-command update logic.
// Depends on cbrm_pkg; instantiated by contiguous_block_ring_manager_unit.
module cbrm_engine import cbrm_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_step,
    input  t_req                  i_req,
    output t_result               o_res
);

    // Compare width: wide enough for any sum of a pointer and a length
    localparam int EXT = ((POS_BITS > LEN_W) ? POS_BITS : LEN_W) + 2;

    logic [CFG_DATA_W-1:0] r_wcap, r_rsv;
    logic [POS_BITS-1:0] r_head, r_tail, r_skip, r_fill, r_cursor, r_limit;
    logic [POS_BITS-1:0] r_written, r_pend_size, r_pend_head;
    logic                r_wbusy, r_rbusy;
    t_place              r_place;

    logic [POS_BITS-1:0] n_head, n_tail, n_skip, n_fill, n_cursor, n_limit;
    logic [POS_BITS-1:0] n_written, n_pend_size, n_pend_head;
    logic                n_wbusy, n_rbusy;
    t_place              n_place;

    logic [EXT-1:0] e_head, e_tail, e_skip, e_fill, e_cursor, e_limit;
    logic [EXT-1:0] e_len, e_chunk, e_cap, e_rsv, e_written, e_pend_size;
    logic [EXT-1:0] e_start, e_reach, e_avail, e_size, e_rem, e_nhead, e_boff;
    logic           empty;
    t_place         kind;
    t_result        res;

    // Widen operands for compares
    assign e_head      = EXT'(r_head);
    assign e_tail      = EXT'(r_tail);
    assign e_skip      = EXT'(r_skip);
    assign e_fill      = EXT'(r_fill);
    assign e_cursor    = EXT'(r_cursor);
    assign e_limit     = EXT'(r_limit);
    assign e_written   = EXT'(r_written);
    assign e_pend_size = EXT'(r_pend_size);
    assign e_len       = EXT'(i_req.length);
    assign e_chunk     = EXT'(i_req.chunk_offset);
    assign e_cap       = EXT'(r_wcap);
    assign e_rsv       = EXT'(r_rsv);
    assign empty       = (r_head == r_tail) && (r_fill == '0);

    // Decode the command and form next state and result
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_skip      = r_skip;
        n_fill      = r_fill;
        n_cursor    = r_cursor;
        n_limit     = r_limit;
        n_written   = r_written;
        n_pend_size = r_pend_size;
        n_pend_head = r_pend_head;
        n_wbusy     = r_wbusy;
        n_rbusy     = r_rbusy;
        n_place     = r_place;
        res         = '0;
        res.status  = ST_OK;
        kind        = PLACE_NONE;
        e_start     = '0;
        e_reach     = '0;
        e_avail     = '0;
        e_size      = '0;
        e_rem       = '0;
        e_nhead     = e_head;
        e_boff      = '0;
        unique case (i_req.cmd)
            CMD_W_RESERVE: begin
                if (r_wbusy) begin
                    res.status = ST_WRITE_BUSY;
                end else begin
                    // pick a placement: after tail, before head, or at zero
                    if (e_len == '0) begin
                        res.status = ST_WRITE_NOTHING;
                    end else if ((e_head < e_tail) || empty) begin
                        if (e_tail + e_len <= e_cap) begin
                            kind    = PLACE_TAIL_END;
                            e_start = e_tail;
                        end else if (e_len <= e_head) begin
                            kind = PLACE_ZERO;
                        end
                    end else if ((e_head > e_tail) && (e_tail + e_len <= e_head)) begin
                        kind    = PLACE_TAIL_HEAD;
                        e_start = e_tail;
                    end
                    if ((e_len != '0) && (kind == PLACE_NONE)) begin
                        res.status = ST_NO_SPACE;
                    end
                    n_place   = kind;
                    n_written = '0;
                    n_cursor  = '0;
                    n_limit   = '0;
                    if (kind != PLACE_NONE) begin
                        n_cursor         = POS_BITS'(e_start);
                        n_limit          = POS_BITS'(e_start + e_len);
                        n_wbusy          = 1'b1;
                        res.block_offset = $signed(e_start[OFS_W-1:0]);
                        res.block_size   = i_req.length;
                    end
                end
            end
            CMD_W_COMMIT: begin
                if (!r_wbusy) begin
                    res.status = ST_WRITE_NOT_START;
                end else if ((e_chunk + e_len > e_limit) || (e_chunk < e_cursor)) begin
                    res.status = ST_OUT_OF_BOUNDS;
                end else begin
                    // advance the cursor; request a move if the chunk sits elsewhere
                    n_cursor         = r_cursor + POS_BITS'(i_req.length);
                    n_written        = r_written + POS_BITS'(i_req.length);
                    res.block_offset = $signed(e_cursor[OFS_W-1:0]);
                    res.block_size   = i_req.length;
                    if ((e_chunk != e_cursor) && (e_len != '0)) begin
                        res.move_valid  = 1'b1;
                        res.move_source = i_req.chunk_offset;
                        res.move_dest   = $signed(e_cursor[OFS_W-1:0]);
                        res.move_length = i_req.length;
                    end
                end
            end
            CMD_W_CLOSE: begin
                if (!r_wbusy) begin
                    res.status = ST_WRITE_NOT_START;
                end else begin
                    n_wbusy = 1'b0;
                    if (r_place == PLACE_NONE) begin
                        res.status = ST_ERROR;
                    end else begin
                        // advance the tail, or restart it at zero after a wrap
                        if (r_place == PLACE_ZERO) begin
                            n_skip = r_tail;
                            n_tail = r_written;
                        end else begin
                            n_tail = r_tail + r_written;
                        end
                        n_fill         = r_fill + r_written;
                        res.block_size = e_written[LEN_W-1:0];
                    end
                end
            end
            CMD_R_OPEN: begin
                if (r_rbusy) begin
                    res.status = ST_READ_BUSY;
                end else if (e_len > e_rsv) begin
                    res.status = ST_ERROR;
                end else begin
                    n_pend_size = '0;
                    n_pend_head = r_head;
                    if (e_len == '0) begin
                        res.status = ST_READ_NOTHING;
                    end else if (empty) begin
                        res.status = ST_EMPTY;
                    end else if ((e_len > e_fill) && i_req.need_complete) begin
                        res.status = ST_INCOMPLETE;
                    end else begin
                        e_reach = e_head + e_len;
                        if (e_head < e_tail) begin
                            // plain read between head and tail
                            e_avail = e_tail - e_head;
                            e_size  = (e_avail < e_len) ? e_avail : e_len;
                            e_boff  = e_head;
                            e_nhead = e_head + e_size;
                        end else if (e_reach == e_skip) begin
                            e_size  = e_len;
                            e_boff  = e_head;
                            e_nhead = '0;
                        end else if (e_reach < e_skip) begin
                            e_size  = e_len;
                            e_boff  = e_head;
                            e_nhead = e_reach;
                        end else begin
                            // read crosses the wrap: move leftover into the reserve
                            e_rem   = (e_skip > e_head) ? (e_skip - e_head) : '0;
                            e_size  = (e_len <= e_fill) ? e_len : e_fill;
                            e_boff  = '0 - e_rem;
                            e_nhead = (e_size > e_rem) ? (e_size - e_rem) : '0;
                        end
                        n_pend_size      = POS_BITS'(e_size);
                        n_pend_head      = POS_BITS'(e_nhead);
                        n_rbusy          = 1'b1;
                        res.block_offset = $signed(e_boff[OFS_W-1:0]);
                        res.block_size   = e_size[LEN_W-1:0];
                        if (e_rem != '0) begin
                            res.move_valid  = 1'b1;
                            res.move_source = e_head[LEN_W-1:0];
                            res.move_dest   = $signed(e_boff[OFS_W-1:0]);
                            res.move_length = e_rem[LEN_W-1:0];
                        end
                    end
                end
            end
            CMD_R_CLOSE: begin
                if (!r_rbusy) begin
                    res.status = ST_READ_NOT_START;
                end else begin
                    // release the read block, fill floors at zero
                    n_rbusy        = 1'b0;
                    n_head         = r_pend_head;
                    n_fill         = (r_fill > r_pend_size) ? (r_fill - r_pend_size) : '0;
                    res.block_size = e_pend_size[LEN_W-1:0];
                end
            end
            CMD_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_skip  = POS_BITS'(r_wcap);
                n_fill  = '0;
                n_wbusy = 1'b0;
                n_rbusy = 1'b0;
            end
            default: begin
                res.status = ST_ERROR;
            end
        endcase
    end

    assign o_res = res;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcap <= WCAP_RESET;
            r_rsv  <= RSV_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WRITE_CAPACITY) begin
                r_wcap <= i_cfg_data;
            end
            if (i_cfg_idx == REG_RESERVE_SIZE) begin
                r_rsv <= i_cfg_data;
            end
        end
    end

    // Update pointer state once per executed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_skip      <= POS_BITS'(WCAP_RESET);
            r_fill      <= '0;
            r_cursor    <= '0;
            r_limit     <= '0;
            r_written   <= '0;
            r_pend_size <= '0;
            r_pend_head <= '0;
            r_wbusy     <= 1'b0;
            r_rbusy     <= 1'b0;
            r_place     <= PLACE_NONE;
        end else if (i_step) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_skip      <= n_skip;
            r_fill      <= n_fill;
            r_cursor    <= n_cursor;
            r_limit     <= n_limit;
            r_written   <= n_written;
            r_pend_size <= n_pend_size;
            r_pend_head <= n_pend_head;
            r_wbusy     <= n_wbusy;
            r_rbusy     <= n_rbusy;
            r_place     <= n_place;
        end
    end

endmodule

FILE: rtl/contiguous_block_ring_manager_unit.sv
// Top level of the contiguous block ring manager: request and result registers.
// Depends on cbrm_pkg and cbrm_engine.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | request command and lengths
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | status, block and move request
//  cfg       | in        | i_cfg_we                      | register index and write data
//
// One request per cycle while the result is not stalled: an accepted request is held in the
// request register, then goes through the command logic into the result register, from
// which it is offered on m_axis.
// Synchronous active-low reset clears pointers, flags, configuration registers and both valid bits.
// A stalled result holds; the request register still takes a request while it is empty,
// so a stalled output backs up two requests before s_axis_tready drops.
module contiguous_block_ring_manager_unit import cbrm_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // length [15:0], chunk_offset [31:16]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // cmd [2:0], need_complete [3]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // block_offset [16:0], block_size [32:17], move_source [48:33],
    // move_dest [65:49], move_length [81:66], zero [87:82]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // status [3:0], move_valid [4]
    output logic [M_TUSER_W-1:0]  m_axis_tuser
);

    logic    r_in_valid, r_out_valid;
    t_req    r_in;
    t_result r_out;
    t_result res;
    logic    advance, step;

    // Move forward whenever the result register is free or being taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    cbrm_engine #(
        .POS_BITS (POS_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_req      (r_in),
        .o_res      (res)
    );

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.cmd           <= s_axis_tuser[2:0];
            r_in.need_complete <= s_axis_tuser[3];
            r_in.length        <= s_axis_tdata[15:0];
            r_in.chunk_offset  <= s_axis_tdata[31:16];
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.move_length, r_out.move_dest, r_out.move_source,
                            r_out.block_size, r_out.block_offset};
    assign m_axis_tuser  = {r_out.move_valid, r_out.status};

endmodule
